FILE: design/cwt_pkg.sv
// Shared constants, types and tables for the cylinder wrap transform.
`default_nettype none
package cwt_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int HEIGHT_W     = COORD_WIDTH - 1;
    localparam int PHASE_W      = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int RZ_W         = COORD_WIDTH + 2;
    localparam int INV_W        = 30;

    localparam logic signed [CORDIC_W-1:0] GAIN_Q30       = CORDIC_W'(652032874);
    localparam logic        [INV_W-1:0]    INV_TWO_PI_Q32 = INV_W'(683565276);

    typedef enum logic [2:0] {
        CFG_Y_OFFSET        = 3'd0,
        CFG_Z_OFFSET        = 3'd1,
        CFG_SPAN_HEIGHT     = 3'd2,
        CFG_BARREL_DIAMETER = 3'd3,
        CFG_TORUS_MODE      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH:0]   z0;
        logic                          err;
    } t_side;

    // arctangent of 2^-i in Q0.32 turns
    function automatic logic signed [CORDIC_W-1:0] atan_turns(input int idx);
        logic signed [CORDIC_W-1:0] v;
        begin
            case (idx)
                0:       v = CORDIC_W'(536870912);
                1:       v = CORDIC_W'(316933406);
                2:       v = CORDIC_W'(167458907);
                3:       v = CORDIC_W'(85004756);
                4:       v = CORDIC_W'(42667331);
                5:       v = CORDIC_W'(21354465);
                6:       v = CORDIC_W'(10679838);
                7:       v = CORDIC_W'(5340245);
                8:       v = CORDIC_W'(2670163);
                9:       v = CORDIC_W'(1335087);
                10:      v = CORDIC_W'(667544);
                11:      v = CORDIC_W'(333772);
                12:      v = CORDIC_W'(166886);
                13:      v = CORDIC_W'(83443);
                14:      v = CORDIC_W'(41722);
                15:      v = CORDIC_W'(20861);
                16:      v = CORDIC_W'(10430);
                17:      v = CORDIC_W'(5215);
                18:      v = CORDIC_W'(2608);
                19:      v = CORDIC_W'(1304);
                20:      v = CORDIC_W'(652);
                21:      v = CORDIC_W'(326);
                22:      v = CORDIC_W'(163);
                23:      v = CORDIC_W'(81);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/cwt_div.sv
// Pipelined floor remainder and restoring division giving the angle phase.
`default_nettype none
module cwt_div import cwt_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic signed [COORD_WIDTH:0] i_y0,
    input  wire t_side                       i_side,
    input  wire logic [HEIGHT_W-1:0]         i_height,
    output logic                             o_valid,
    output logic [ANGLE_BITS-1:0]            o_phase,
    output t_side                            o_side
);

    logic [COORD_WIDTH-1:0] r_u    [0:COORD_WIDTH];
    logic [HEIGHT_W-1:0]    r_rem  [0:COORD_WIDTH];
    logic                   r_neg  [0:COORD_WIDTH];
    logic                   r_v    [0:COORD_WIDTH];
    t_side                  r_sd   [0:COORD_WIDTH];
    logic [HEIGHT_W-1:0]    n_rem  [1:COORD_WIDTH];

    logic [HEIGHT_W-1:0]    r_prem [0:ANGLE_BITS];
    logic [ANGLE_BITS-1:0]  r_ph   [0:ANGLE_BITS];
    logic                   r_pv   [0:ANGLE_BITS];
    t_side                  r_ps   [0:ANGLE_BITS];
    logic [HEIGHT_W-1:0]    n_prem [1:ANGLE_BITS];
    logic                   n_bit  [1:ANGLE_BITS];

    always_comb begin
        logic [HEIGHT_W:0] trial;
        for (int k = 1; k <= COORD_WIDTH; k++) begin
            trial = {r_rem[k-1], r_u[k-1][COORD_WIDTH-1]};
            if (trial >= {1'b0, i_height}) begin
                n_rem[k] = HEIGHT_W'(trial - {1'b0, i_height});
            end else begin
                n_rem[k] = trial[HEIGHT_W-1:0];
            end
        end
    end

    always_comb begin
        logic [HEIGHT_W:0] trial;
        for (int j = 1; j <= ANGLE_BITS; j++) begin
            trial = {r_prem[j-1], 1'b0};
            n_bit[j] = (trial >= {1'b0, i_height});
            if (n_bit[j]) begin
                n_prem[j] = HEIGHT_W'(trial - {1'b0, i_height});
            end else begin
                n_prem[j] = trial[HEIGHT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= COORD_WIDTH; k++) r_v[k] <= 1'b0;
            for (int j = 0; j <= ANGLE_BITS; j++) r_pv[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= COORD_WIDTH; k++) r_v[k] <= r_v[k-1];
            r_pv[0] <= r_v[COORD_WIDTH];
            for (int j = 1; j <= ANGLE_BITS; j++) r_pv[j] <= r_pv[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_y0[COORD_WIDTH];
            r_u[0]   <= i_y0[COORD_WIDTH] ? ~i_y0[COORD_WIDTH-1:0] : i_y0[COORD_WIDTH-1:0];
            r_rem[0] <= '0;
            r_sd[0]  <= i_side;
            for (int k = 1; k <= COORD_WIDTH; k++) begin
                r_neg[k] <= r_neg[k-1];
                r_u[k]   <= {r_u[k-1][COORD_WIDTH-2:0], 1'b0};
                r_rem[k] <= n_rem[k];
                r_sd[k]  <= r_sd[k-1];
            end
            // negative offsets wrap into [0, height)
            r_prem[0] <= r_neg[COORD_WIDTH] ? (i_height - HEIGHT_W'(1) - r_rem[COORD_WIDTH])
                                            : r_rem[COORD_WIDTH];
            r_ph[0]   <= '0;
            r_ps[0]   <= r_sd[COORD_WIDTH];
            for (int j = 1; j <= ANGLE_BITS; j++) begin
                r_prem[j] <= n_prem[j];
                r_ph[j]   <= {r_ph[j-1][ANGLE_BITS-2:0], n_bit[j]};
                r_ps[j]   <= r_ps[j-1];
            end
        end
    end

    assign o_valid = r_pv[ANGLE_BITS];
    assign o_phase = r_ph[ANGLE_BITS];
    assign o_side  = r_ps[ANGLE_BITS];

endmodule
`default_nettype wire

FILE: design/cwt_cordic.sv
// Pipelined CORDIC rotator producing cosine and sine of the phase in Q4.30.
`default_nettype none
module cwt_cordic import cwt_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [ANGLE_BITS-1:0]      i_phase,
    input  wire t_side                      i_side,
    output logic                            o_valid,
    output logic signed [CORDIC_W-1:0]      o_cos,
    output logic signed [CORDIC_W-1:0]      o_sin,
    output t_side                           o_side
);

    logic signed [CORDIC_W-1:0] r_cx [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_cy [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_az [0:CORDIC_STEPS];
    logic [1:0]                 r_q  [0:CORDIC_STEPS];
    logic                       r_v  [0:CORDIC_STEPS];
    t_side                      r_sd [0:CORDIC_STEPS];
    logic                       r_ov;
    logic signed [CORDIC_W-1:0] r_c;
    logic signed [CORDIC_W-1:0] r_s;
    t_side                      r_os;

    logic [PHASE_W-1:0] turn;
    logic [PHASE_W-1:0] folded;
    logic [1:0]         quad;

    always_comb begin
        turn   = {i_phase, (PHASE_W - ANGLE_BITS)'(0)};
        quad   = 2'((turn + PHASE_W'(32'h2000_0000)) >> 30);
        folded = turn - {quad, (PHASE_W - 2)'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= CORDIC_STEPS; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= GAIN_Q30;
            r_cy[0] <= '0;
            r_az[0] <= CORDIC_W'($signed(folded));
            r_q[0]  <= quad;
            r_sd[0] <= i_side;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                if (!r_az[k-1][CORDIC_W-1]) begin
                    r_cx[k] <= r_cx[k-1] - (r_cy[k-1] >>> (k - 1));
                    r_cy[k] <= r_cy[k-1] + (r_cx[k-1] >>> (k - 1));
                    r_az[k] <= r_az[k-1] - atan_turns(k - 1);
                end else begin
                    r_cx[k] <= r_cx[k-1] + (r_cy[k-1] >>> (k - 1));
                    r_cy[k] <= r_cy[k-1] - (r_cx[k-1] >>> (k - 1));
                    r_az[k] <= r_az[k-1] + atan_turns(k - 1);
                end
                r_q[k]  <= r_q[k-1];
                r_sd[k] <= r_sd[k-1];
            end
            case (r_q[CORDIC_STEPS])
                2'd0: begin
                    r_c <= r_cx[CORDIC_STEPS];
                    r_s <= r_cy[CORDIC_STEPS];
                end
                2'd1: begin
                    r_c <= -r_cy[CORDIC_STEPS];
                    r_s <= r_cx[CORDIC_STEPS];
                end
                2'd2: begin
                    r_c <= -r_cx[CORDIC_STEPS];
                    r_s <= -r_cy[CORDIC_STEPS];
                end
                default: begin
                    r_c <= r_cy[CORDIC_STEPS];
                    r_s <= -r_cx[CORDIC_STEPS];
                end
            endcase
            r_os <= r_sd[CORDIC_STEPS];
        end
    end

    assign o_valid = r_ov;
    assign o_cos   = r_c;
    assign o_sin   = r_s;
    assign o_side  = r_os;

endmodule
`default_nettype wire

FILE: design/cwt_scale.sv
// Radius scaling: split multiply, rounding, saturation and output register.
`default_nettype none
module cwt_scale import cwt_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [CORDIC_W-1:0]    i_cos,
    input  wire logic signed [CORDIC_W-1:0]    i_sin,
    input  wire t_side                         i_side,
    input  wire logic [HEIGHT_W-1:0]           i_radius,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_wrapped_x,
    output logic signed [COORD_WIDTH-1:0]      o_wrapped_y,
    output logic signed [COORD_WIDTH-1:0]      o_wrapped_z,
    output logic                               o_height_error
);

    localparam int LO_W  = RZ_W / 2;
    localparam int HI_W  = RZ_W - LO_W;
    localparam int UB_W  = CORDIC_W - 1;
    localparam int SUM_W = RZ_W + UB_W + 1;
    localparam int M_W   = SUM_W - 30;

    logic                  r_av, r_bv, r_ov;
    logic [RZ_W-1:0]       r_ua;
    logic [UB_W-1:0]       r_ubc, r_ubs;
    logic                  r_nc, r_ns, r_bnc, r_bns;
    t_side                 r_as, r_bs;
    logic [LO_W+UB_W-1:0]  r_lc, r_ls;
    logic [HI_W+UB_W-1:0]  r_hc, r_hs;
    logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;
    logic                  r_err;

    logic signed [RZ_W-1:0] rz;
    logic [SUM_W-1:0]       sum_c, sum_s;

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic [M_W-1:0] m,
                                                          input logic neg);
        logic [M_W-1:0] lim;
        begin
            lim = M_W'(1) << (COORD_WIDTH - 1);
            if (neg) begin
                if (m >= lim) return {1'b1, (COORD_WIDTH - 1)'(0)};
                return -$signed(m[COORD_WIDTH-1:0]);
            end
            if (m > lim - M_W'(1)) return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
            return $signed(m[COORD_WIDTH-1:0]);
        end
    endfunction

    always_comb begin
        rz    = $signed(RZ_W'({1'b0, i_radius})) + RZ_W'(i_side.z0);
        sum_c = (SUM_W'(r_hc) << LO_W) + SUM_W'(r_lc) + (SUM_W'(1) << 29);
        sum_s = (SUM_W'(r_hs) << LO_W) + SUM_W'(r_ls) + (SUM_W'(1) << 29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_av <= i_valid;
            r_bv <= r_av;
            r_ov <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua  <= rz[RZ_W-1] ? RZ_W'(-rz) : RZ_W'(rz);
            r_ubc <= i_cos[CORDIC_W-1] ? UB_W'(-i_cos) : UB_W'(i_cos);
            r_ubs <= i_sin[CORDIC_W-1] ? UB_W'(-i_sin) : UB_W'(i_sin);
            r_nc  <= rz[RZ_W-1] ^ i_cos[CORDIC_W-1];
            r_ns  <= rz[RZ_W-1] ^ i_sin[CORDIC_W-1];
            r_as  <= i_side;

            r_lc  <= r_ua[LO_W-1:0] * r_ubc;
            r_hc  <= r_ua[RZ_W-1:LO_W] * r_ubc;
            r_ls  <= r_ua[LO_W-1:0] * r_ubs;
            r_hs  <= r_ua[RZ_W-1:LO_W] * r_ubs;
            r_bnc <= r_nc;
            r_bns <= r_ns;
            r_bs  <= r_as;

            r_x   <= r_bs.x;
            r_err <= r_bs.err;
            r_y   <= r_bs.err ? '0 : sat(M_W'(sum_c >> 30), r_bnc);
            r_z   <= r_bs.err ? '0 : sat(M_W'(sum_s >> 30), r_bns);
        end
    end

    assign o_valid        = r_ov;
    assign o_wrapped_x    = r_x;
    assign o_wrapped_y    = r_y;
    assign o_wrapped_z    = r_z;
    assign o_height_error = r_err;

endmodule
`default_nettype wire

FILE: design/cylinder_wrap_transform.sv
// Top level: configuration registers, offset stage and the wrap pipeline.
// Pipeline order: input register, divider, CORDIC, scaling.
// Throughput: one request per cycle while the output is not stalled; the divider and CORDIC are fully unrolled stages.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset: synchronous active low; clears valid bits and restores register defaults.
`default_nettype none
module cylinder_wrap_transform import cwt_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0]      o_wrapped_x,
    output logic signed [COORD_WIDTH-1:0]      o_wrapped_y,
    output logic signed [COORD_WIDTH-1:0]      o_wrapped_z,
    output logic                               o_height_error,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]        i_cfg_data
);

    logic signed [COORD_WIDTH-1:0] r_y_offset, r_z_offset;
    logic [HEIGHT_W-1:0]           r_height, r_diameter, r_radius;
    logic                          r_torus;
    logic                          r_iv;
    logic signed [COORD_WIDTH:0]   r_y0;
    t_side                         r_side;
    logic                          en;
    logic [HEIGHT_W+INV_W-1:0]     torus_prod;

    logic                          dv, cv;
    logic [ANGLE_BITS-1:0]         d_phase;
    t_side                         d_side, c_side;
    logic signed [CORDIC_W-1:0]    c_cos, c_sin;

    assign o_stall     = o_valid && i_stall;
    assign en          = !o_stall;
    assign o_cfg_ready = 1'b1;
    assign torus_prod  = r_height * INV_TWO_PI_Q32 + ((HEIGHT_W + INV_W)'(1) << 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_offset <= '0;
            r_z_offset <= '0;
            r_height   <= HEIGHT_W'(65536);
            r_diameter <= HEIGHT_W'(694682);
            r_torus    <= 1'b0;
            r_iv       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_Y_OFFSET:        r_y_offset <= i_cfg_data;
                    CFG_Z_OFFSET:        r_z_offset <= i_cfg_data;
                    CFG_SPAN_HEIGHT:     r_height   <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_BARREL_DIAMETER: r_diameter <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_TORUS_MODE:      r_torus    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (en) begin
                r_iv <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_radius <= r_torus ? HEIGHT_W'(torus_prod >> 32) : (r_diameter >> 1);
        if (en) begin
            r_y0       <= (COORD_WIDTH + 1)'(i_point_y) - (COORD_WIDTH + 1)'(r_y_offset);
            r_side.z0  <= (COORD_WIDTH + 1)'(i_point_z) - (COORD_WIDTH + 1)'(r_z_offset);
            r_side.err <= (r_height == '0);
            r_side.x   <= (r_height == '0) ? '0 : i_point_x;
        end
    end

    cwt_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_iv),
        .i_y0     (r_y0),
        .i_side   (r_side),
        .i_height (r_height),
        .o_valid  (dv),
        .o_phase  (d_phase),
        .o_side   (d_side)
    );

    cwt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv),
        .i_phase (d_phase),
        .i_side  (d_side),
        .o_valid (cv),
        .o_cos   (c_cos),
        .o_sin   (c_sin),
        .o_side  (c_side)
    );

    cwt_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (cv),
        .i_cos          (c_cos),
        .i_sin          (c_sin),
        .i_side         (c_side),
        .i_radius       (r_radius),
        .o_valid        (o_valid),
        .o_wrapped_x    (o_wrapped_x),
        .o_wrapped_y    (o_wrapped_y),
        .o_wrapped_z    (o_wrapped_z),
        .o_height_error (o_height_error)
    );

    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a pending result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_height_error) |->
            (o_wrapped_x == '0 && o_wrapped_y == '0 && o_wrapped_z == '0))
        else $error("height error result carries nonzero coordinates");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_wrapped_y) && $stable(o_wrapped_z)))
        else $error("pipeline advanced under stall");

endmodule
`default_nettype wire
